FILE: rtl/msbvt_pkg.sv
// Package: shared constants and types for the multi-slot bounded vector table
package msbvt_pkg;
   localparam int NUM_SLOTS   = 10;
   localparam int SLOT_CAP    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int SLOT_W  = 4;
   localparam int IDX_W   = $clog2(SLOT_CAP);
   localparam int FILL_W  = $clog2(SLOT_CAP + 1);
   localparam int ADDR_W  = $clog2(NUM_SLOTS * SLOT_CAP);
   localparam int DEPTH   = NUM_SLOTS * SLOT_CAP;
   localparam int COUNT_W = 7;

   typedef enum logic [2:0] {
      CMD_CREATE = 3'd0, CMD_APPEND = 3'd1, CMD_DEL_LAST = 3'd2, CMD_DEL_VAL = 3'd3,
      CMD_RESIZE = 3'd4, CMD_COUNT  = 3'd5, CMD_READ     = 3'd6, CMD_READ_SORT = 3'd7
   } cmd_type;

   typedef enum logic [3:0] {
      ST_OK = 4'd0, ST_BAD_SLOT = 4'd1, ST_BAD_SIZE = 4'd2, ST_EXISTS = 4'd3,
      ST_NO_MEM = 4'd4, ST_FULL = 4'd5, ST_NO_SLOT = 4'd6, ST_EMPTY = 4'd7,
      ST_NOT_FOUND = 4'd8, ST_BAD_NEW = 4'd9
   } status_type;
endpackage

FILE: rtl/msbvt_entry_ram.sv
// Entry memory: one write port, one registered read port
module msbvt_entry_ram import msbvt_pkg::*; (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic signed [VALUE_WIDTH-1:0] wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic signed [VALUE_WIDTH-1:0] rd_data
);
   logic signed [VALUE_WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/multi_slot_bounded_vector_table.sv
// Top level: slot table with per-slot bounded vectors held in one entry memory
//  channel | dir | handshake             | payload
//  req     | in  | req_valid/req_ready   | command, slot, amount, operand_value
//  rsp     | out | rsp_valid/rsp_ready   | status, element, element_valid, element_count, last
// One transaction at a time. Delete by value walks the row through the entry memory port.
// Sorted read does a selection pass over the row per output.
// Plain read returns the row one element per response, in index order.
// reset closes all slots; entry memory is not cleared. rsp stalls hold the FSM.
module multi_slot_bounded_vector_table import msbvt_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_command,
   input  logic [3:0]                    req_slot,
   input  logic signed [7:0]             req_amount,
   input  logic signed [VALUE_WIDTH-1:0] req_operand_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [3:0]                    rsp_status,
   output logic signed [VALUE_WIDTH-1:0] rsp_element,
   output logic                          rsp_element_valid,
   output logic [COUNT_W-1:0]            rsp_element_count,
   output logic                          rsp_last
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_FIND_RD, S_FIND_CHK, S_SHIFT_RD, S_SHIFT_WR,
      S_READ_RD, S_READ_OUT, S_SORT_RD, S_SORT_CHK, S_RESP
   } state_type;

   state_type state_ff;
   logic [NUM_SLOTS-1:0] open_ff;
   logic [FILL_W-1:0] cap_ff  [NUM_SLOTS];
   logic [FILL_W-1:0] fill_ff [NUM_SLOTS];

   cmd_type cmd_ff;
   logic [SLOT_W-1:0] sidx_ff;
   logic signed [7:0] amt_ff;
   logic signed [VALUE_WIDTH-1:0] val_ff;
   logic [FILL_W-1:0] i_ff, j_ff;
   // sorted read: previous emitted (value, index) and current best
   logic signed [VALUE_WIDTH-1:0] prev_v_ff, best_v_ff;
   logic [IDX_W-1:0] prev_i_ff, best_i_ff;
   logic have_prev_ff, have_best_ff;

   logic                          rsp_valid_ff, rsp_last_ff, rsp_ev_ff;
   logic [3:0]                    rsp_status_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_elem_ff;
   logic [COUNT_W-1:0]            rsp_cnt_ff;

   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr, rd_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data, rd_data;

   msbvt_entry_ram u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   logic [FILL_W-1:0] fill_cur, cap_cur;
   logic [ADDR_W-1:0] row_base;
   logic signed [9:0] ncap;
   logic              cand;
   assign fill_cur = fill_ff[sidx_ff];
   assign cap_cur  = cap_ff[sidx_ff];
   assign row_base = ADDR_W'(sidx_ff * SLOT_CAP);
   assign ncap     = 10'(signed'({1'b0, cap_cur})) + 10'(amt_ff);
   // element strictly after previous in (value, index) order
   assign cand = !have_prev_ff || (rd_data > prev_v_ff) ||
                 (rd_data == prev_v_ff && IDX_W'(j_ff) > prev_i_ff);

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element       = rsp_elem_ff;
   assign rsp_element_valid = rsp_ev_ff;
   assign rsp_element_count = rsp_cnt_ff;
   assign rsp_last          = rsp_last_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = row_base + ADDR_W'(fill_cur);
      wr_data = val_ff;
      rd_addr = row_base + ADDR_W'(i_ff);
      unique case (state_ff)
         S_DECODE: begin
            wr_en = (cmd_ff == CMD_APPEND) && open_ff[sidx_ff] && fill_cur < cap_cur;
         end
         S_SHIFT_RD: rd_addr = row_base + ADDR_W'(j_ff + 1'b1);
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = row_base + ADDR_W'(j_ff);
            wr_data = rd_data;
         end
         S_SORT_RD, S_SORT_CHK: rd_addr = row_base + ADDR_W'(j_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            cap_ff[k]  <= '0;
            fill_ff[k] <= '0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= cmd_type'(req_command);
                  sidx_ff  <= req_slot - 1'b1;
                  amt_ff   <= req_amount;
                  val_ff   <= req_operand_value;
                  rsp_elem_ff <= '0;
                  rsp_ev_ff   <= 1'b0;
                  rsp_last_ff <= 1'b1;
                  if (req_slot < 4'd1 || req_slot > 4'(NUM_SLOTS)) begin
                     rsp_status_ff <= ST_BAD_SLOT;
                     rsp_cnt_ff    <= '0;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= S_RESP;
                  end else begin
                     state_ff <= S_DECODE;
                  end
               end
            end
            S_DECODE: begin
               rsp_cnt_ff    <= COUNT_W'(fill_cur);
               rsp_status_ff <= ST_OK;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= S_RESP;
               i_ff          <= '0;
               have_prev_ff  <= 1'b0;
               if (cmd_ff == CMD_CREATE) begin
                  if (amt_ff < 8'sd1) rsp_status_ff <= ST_BAD_SIZE;
                  else if (open_ff[sidx_ff]) rsp_status_ff <= ST_EXISTS;
                  else if (amt_ff > 8'(SLOT_CAP)) rsp_status_ff <= ST_NO_MEM;
                  else begin
                     open_ff[sidx_ff] <= 1'b1;
                     cap_ff[sidx_ff]  <= FILL_W'(amt_ff);
                     fill_ff[sidx_ff] <= '0;
                     rsp_cnt_ff       <= '0;
                  end
               end else if (!open_ff[sidx_ff]) begin
                  rsp_status_ff <= ST_NO_SLOT;
               end else begin
                  unique case (cmd_ff)
                     CMD_APPEND: begin
                        if (fill_cur < cap_cur) begin
                           fill_ff[sidx_ff] <= fill_cur + 1'b1;
                           rsp_cnt_ff <= COUNT_W'(fill_cur) + 1'b1;
                        end else rsp_status_ff <= ST_FULL;
                     end
                     CMD_DEL_LAST: begin
                        if (fill_cur == '0) rsp_status_ff <= ST_EMPTY;
                        else begin
                           fill_ff[sidx_ff] <= fill_cur - 1'b1;
                           rsp_cnt_ff <= COUNT_W'(fill_cur) - 1'b1;
                        end
                     end
                     CMD_DEL_VAL: begin
                        if (fill_cur == '0) rsp_status_ff <= ST_EMPTY;
                        else begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= S_FIND_RD;
                        end
                     end
                     CMD_RESIZE: begin
                        if (ncap < 10'sd1) rsp_status_ff <= ST_BAD_NEW;
                        else if (ncap > 10'(SLOT_CAP)) rsp_status_ff <= ST_NO_MEM;
                        else begin
                           cap_ff[sidx_ff] <= FILL_W'(ncap);
                           if (10'(fill_cur) > ncap) begin
                              fill_ff[sidx_ff] <= FILL_W'(ncap);
                              rsp_cnt_ff <= COUNT_W'(ncap);
                           end
                        end
                     end
                     CMD_COUNT: begin
                        if (fill_cur == '0) rsp_status_ff <= ST_EMPTY;
                     end
                     CMD_READ, CMD_READ_SORT: begin
                        if (fill_cur != '0) begin
                           rsp_valid_ff <= 1'b0;
                           j_ff         <= '0;
                           have_best_ff <= 1'b0;
                           state_ff <= (cmd_ff == CMD_READ) ? S_READ_RD : S_SORT_RD;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_FIND_RD: state_ff <= S_FIND_CHK;
            S_FIND_CHK: begin
               if (rd_data == val_ff) begin
                  j_ff     <= i_ff;
                  state_ff <= S_SHIFT_RD;
               end else if (i_ff + 1'b1 >= fill_cur) begin
                  rsp_status_ff <= ST_NOT_FOUND;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_RESP;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_FIND_RD;
               end
            end
            S_SHIFT_RD: begin
               if (j_ff + 1'b1 >= fill_cur) begin
                  fill_ff[sidx_ff] <= fill_cur - 1'b1;
                  rsp_cnt_ff       <= COUNT_W'(fill_cur) - 1'b1;
                  rsp_valid_ff     <= 1'b1;
                  state_ff         <= S_RESP;
               end else state_ff <= S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
               j_ff     <= j_ff + 1'b1;
               state_ff <= S_SHIFT_RD;
            end
            S_READ_RD: state_ff <= S_READ_OUT;
            S_READ_OUT: begin
               rsp_elem_ff  <= rd_data;
               rsp_ev_ff    <= 1'b1;
               rsp_last_ff  <= (i_ff + 1'b1 == fill_cur);
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end
            S_SORT_RD: state_ff <= S_SORT_CHK;
            S_SORT_CHK: begin
               if (cand && (!have_best_ff || rd_data < best_v_ff)) begin
                  best_v_ff    <= rd_data;
                  best_i_ff    <= IDX_W'(j_ff);
                  have_best_ff <= 1'b1;
               end
               if (j_ff + 1'b1 >= fill_cur) begin
                  rsp_elem_ff  <= (cand && (!have_best_ff || rd_data < best_v_ff))
                                  ? rd_data : best_v_ff;
                  prev_v_ff    <= (cand && (!have_best_ff || rd_data < best_v_ff))
                                  ? rd_data : best_v_ff;
                  prev_i_ff    <= (cand && (!have_best_ff || rd_data < best_v_ff))
                                  ? IDX_W'(j_ff) : best_i_ff;
                  have_prev_ff <= 1'b1;
                  rsp_ev_ff    <= 1'b1;
                  rsp_last_ff  <= (i_ff + 1'b1 == fill_cur);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= S_SORT_RD;
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) state_ff <= S_IDLE;
                  else begin
                     i_ff         <= i_ff + 1'b1;
                     j_ff         <= '0;
                     have_best_ff <= 1'b0;
                     state_ff <= (cmd_ff == CMD_READ) ? S_READ_RD : S_SORT_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request accepted while response pending");
   a_ev_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_element_valid) |-> (rsp_status == ST_OK))
      else $error("element with bad status");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_element_count <= COUNT_W'(SLOT_CAP)))
      else $error("count out of range");
`endif
endmodule
